// ===== sv/mws_pkg.sv =====
package mws_pkg;

  localparam int SHAPE_W = 16;
  localparam int TAB_W   = 31;
  localparam int WAVE_W  = 33;

  localparam int unsigned HALF_PI_Q30 = 32'd1686629713;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

  localparam logic [17:0] U_ONE_THIRD  = 18'd65535;
  localparam logic [17:0] U_TWO_THIRDS = 18'd131070;
  localparam logic [17:0] U_FULL       = 18'd196605;
  localparam logic [15:0] F_FULL       = 16'hFFFF;

  // 65535 * 2^31 offset plus half of 65535 for round to nearest
  localparam logic signed [49:0] BLEND_BIAS = 50'sh7FFF_8000_7FFF;

  typedef enum logic [1:0] {
    THIRD_SINE_TRI   = 2'd0,
    THIRD_TRI_SAW    = 2'd1,
    THIRD_SAW_SQUARE = 2'd2
  } third_t;

  typedef struct packed {
    logic [1:0]         quad;
    logic [29:0]        frac;
    logic [31:0]        p;
    third_t             third;
    logic [SHAPE_W-1:0] f;
  } s1_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic out;
  } pipe_ctl_t;

endpackage

// ===== sv/mws_sine_rom.sv =====
module mws_sine_rom #(
  parameter int DEPTH = 256,
  parameter int AW    = 9
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output logic [mws_pkg::TAB_W-1:0] rd_a,
  output logic [mws_pkg::TAB_W-1:0] rd_b
);
  import mws_pkg::*;

  typedef logic [2*TAB_W-1:0] rom_t [DEPTH+1];

  // Each word holds an entry and its upper neighbor, so one read serves interpolation.
  function automatic rom_t build_rom();
    logic [63:0]        tab [DEPTH+1];
    rom_t               rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    for (int i = 0; i <= DEPTH; i++) begin
      x    = (64'(HALF_PI_Q30) * 64'(i)) / DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      acc  = signed'(x);
      term = ((term * x2) >> 30) / 6;   acc = acc - signed'(term);
      term = ((term * x2) >> 30) / 20;  acc = acc + signed'(term);
      term = ((term * x2) >> 30) / 42;  acc = acc - signed'(term);
      term = ((term * x2) >> 30) / 72;  acc = acc + signed'(term);
      term = ((term * x2) >> 30) / 110; acc = acc - signed'(term);
      term = ((term * x2) >> 30) / 156; acc = acc + signed'(term);
      term = ((term * x2) >> 30) / 210; acc = acc - signed'(term);
      term = ((term * x2) >> 30) / 272; acc = acc + signed'(term);
      if (acc < 64'sd0) acc = 64'sd0;
      if (acc > 64'sd1073741824) acc = 64'sd1073741824;
      tab[i] = unsigned'(acc);
    end
    for (int i = 0; i < DEPTH; i++) begin
      rom[i] = {tab[i+1][TAB_W-1:0], tab[i][TAB_W-1:0]};
    end
    rom[DEPTH] = {tab[DEPTH][TAB_W-1:0], tab[DEPTH][TAB_W-1:0]};
    return rom;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [2*TAB_W-1:0] rd_word_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word_r <= ROM[rd_addr];
    end
  end

  assign rd_a = rd_word_r[TAB_W-1:0];
  assign rd_b = rd_word_r[2*TAB_W-1:TAB_W];

endmodule

// ===== sv/mws_wave.sv =====
module mws_wave (
  input  logic                             clk,
  input  mws_pkg::pipe_ctl_t               ctl,
  input  mws_pkg::s1_t                     s1,
  input  logic [mws_pkg::TAB_W-1:0]        rom_a,
  input  logic [mws_pkg::TAB_W-1:0]        rom_b,
  output logic signed [mws_pkg::WAVE_W-1:0] lo,
  output logic signed [mws_pkg::WAVE_W-1:0] hi,
  output logic [mws_pkg::SHAPE_W-1:0]      f
);
  import mws_pkg::*;

  // stage 2: interpolation product and piecewise-linear waves
  logic [TAB_W-1:0]         a_r, a_nxt;
  logic signed [62:0]       iprod_r, iprod_nxt;
  logic                     neg_r, neg_nxt;
  logic                     sine_sel_r, sine_sel_nxt;
  logic [SHAPE_W-1:0]       f2_r, f2_nxt;
  logic signed [WAVE_W-1:0] wlo_r, wlo_nxt;
  logic signed [WAVE_W-1:0] whi_r, whi_nxt;

  logic signed [31:0]       diff;
  logic signed [34:0]       two_p;
  logic signed [34:0]       tri_w;
  logic signed [WAVE_W-1:0] tri_v, saw_v, sq_v;

  always_comb begin
    diff      = signed'({1'b0, rom_b}) - signed'({1'b0, rom_a});
    iprod_nxt = 63'(diff) * signed'({1'b0, s1.frac});
    a_nxt     = rom_a;
    neg_nxt   = s1.quad[1];
    f2_nxt    = s1.f;
    sine_sel_nxt = (s1.third == THIRD_SINE_TRI);

    two_p = signed'({2'b00, s1.p, 1'b0});
    if (s1.p[31:30] == 2'b00) begin
      tri_w = two_p;
    end else if (s1.p <= 32'hC000_0000) begin
      tri_w = 35'sd4294967296 - two_p;
    end else begin
      tri_w = two_p - 35'sd8589934592;
    end
    tri_v = tri_w[WAVE_W-1:0];
    saw_v = signed'({s1.p[31], s1.p});
    sq_v  = s1.p[31] ? -33'sd2147483648 : 33'sd2147483648;

    unique case (s1.third)
      THIRD_SINE_TRI: begin
        wlo_nxt = tri_v;
        whi_nxt = tri_v;
      end
      THIRD_TRI_SAW: begin
        wlo_nxt = tri_v;
        whi_nxt = saw_v;
      end
      THIRD_SAW_SQUARE: begin
        wlo_nxt = saw_v;
        whi_nxt = sq_v;
      end
      default: begin
        wlo_nxt = saw_v;
        whi_nxt = sq_v;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.s2) begin
      a_r        <= a_nxt;
      iprod_r    <= iprod_nxt;
      neg_r      <= neg_nxt;
      sine_sel_r <= sine_sel_nxt;
      f2_r       <= f2_nxt;
      wlo_r      <= wlo_nxt;
      whi_r      <= whi_nxt;
    end
  end

  // stage 3: finish sine, select the two waves
  logic signed [33:0]       mag;
  logic signed [WAVE_W-1:0] mag2, sine_v;
  logic signed [WAVE_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [SHAPE_W-1:0]       f3_r, f3_nxt;

  always_comb begin
    mag    = signed'({3'b000, a_r}) + 34'(iprod_r >>> 30);
    mag2   = signed'({mag[31:0], 1'b0});
    sine_v = neg_r ? -mag2 : mag2;
    lo_nxt = sine_sel_r ? sine_v : wlo_r;
    hi_nxt = whi_r;
    f3_nxt = f2_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.s3) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      f3_r <= f3_nxt;
    end
  end

  assign lo = lo_r;
  assign hi = hi_r;
  assign f  = f3_r;

endmodule

// ===== sv/mws_mix.sv =====
module mws_mix #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  mws_pkg::pipe_ctl_t                ctl,
  input  logic signed [mws_pkg::WAVE_W-1:0] lo,
  input  logic signed [mws_pkg::WAVE_W-1:0] hi,
  input  logic [mws_pkg::SHAPE_W-1:0]       f,
  output logic signed [SAMPLE_BITS-1:0]     sample
);
  import mws_pkg::*;

  localparam int SHIFT = 32 - SAMPLE_BITS;

  // stage 4: weight the difference of the two waves
  logic signed [33:0]       d;
  logic signed [50:0]       prod_r, prod_nxt;
  logic signed [WAVE_W-1:0] lo4_r;

  always_comb begin
    d        = 34'(hi) - 34'(lo);
    prod_nxt = 51'(d) * signed'({1'b0, f});
  end

  always_ff @(posedge clk) begin
    if (ctl.s4) begin
      prod_r <= prod_nxt;
      lo4_r  <= lo;
    end
  end

  // stage 5: lo*65535 + weighted difference, offset positive
  logic signed [49:0] xs;
  logic [47:0]        x_r, x_nxt;

  always_comb begin
    xs    = (50'(lo4_r) <<< 16) - 50'(lo4_r) + 50'(prod_r) + BLEND_BIAS;
    x_nxt = xs[47:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.s5) begin
      x_r <= x_nxt;
    end
  end

  // stage 6: divide by 65535 using 2^16 = 1 (mod 65535)
  logic [17:0] dsum;
  logic [16:0] rem;
  logic        corr;
  logic [32:0] q_r, q_nxt;

  always_comb begin
    dsum  = 18'(x_r[47:32]) + 18'(x_r[31:16]) + 18'(x_r[15:0]);
    rem   = {1'b0, dsum[15:0]} + 17'(dsum[17:16]);
    corr  = (rem >= 17'(U_ONE_THIRD));
    q_nxt = {1'b0, x_r[47:32], 16'h0000} + 33'(x_r[47:32]) + 33'(x_r[31:16])
            + 33'(dsum[17:16]) + 33'(corr);
  end

  always_ff @(posedge clk) begin
    if (ctl.s6) begin
      q_r <= q_nxt;
    end
  end

  // output register: round half up, remove offset, saturate +1.0
  logic [33:0]                  qr;
  logic [SAMPLE_BITS:0]         o;
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;

  always_comb begin
    qr = {1'b0, q_r} + (34'd1 << (SHIFT - 1));
    o  = qr[32:SHIFT];
    if (o[SAMPLE_BITS]) begin
      sample_nxt = signed'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    end else begin
      sample_nxt = signed'({~o[SAMPLE_BITS-1], o[SAMPLE_BITS-2:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out) begin
      sample_r <= sample_nxt;
    end
  end

  assign sample = sample_r;

endmodule

// ===== sv/morphing_waveform_sampler.sv =====
// Throughput: one transaction per cycle, until a held out_stall fills every stage;
// one read of the single-port sine ROM per item, each ROM word carrying a table entry
// together with its upper neighbor.
// Reset (rst_n low, synchronous): clears every stage valid bit and out_valid.
// The sine ROM is constant and needs no clearing pass.
module morphing_waveform_sampler #(
  parameter int PHASE_BITS         = 16,
  parameter int SAMPLE_BITS        = 16,
  parameter int SINE_QUARTER_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [PHASE_BITS-1:0]         in_phase,
  input  logic [mws_pkg::SHAPE_W-1:0]   in_shape,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);
  import mws_pkg::*;

  localparam int AW  = $clog2(SINE_QUARTER_DEPTH + 1);
  localparam int PW  = 30 + AW;
  localparam int NST = 6;

  // ---------------------------------------------------------------------------
  // Pipeline control. Each stage loads when it is empty or when the stage after
  // it loads, so bubbles collapse and a waiting result blocks intake only once
  // every stage is occupied.
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld_r, vld_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [NST:0]   en;
  pipe_ctl_t      ctl;

  always_comb begin
    en[NST] = !out_valid_r || !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    // advance each valid bit when its stage loads, hold otherwise
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NST; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
    out_valid_nxt = en[NST] ? vld_r[NST-1] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign ctl = '{s1: en[0], s2: en[1], s3: en[2], s4: en[3], s5: en[4], s6: en[5],
                 out: en[NST]};

  assign in_stall  = !en[0];
  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Front end: widen the phase to Q0.32, fold it into a quarter wave, find the
  // ROM address and interpolation fraction, and split the knob into a third and
  // a crossfade weight.
  // ---------------------------------------------------------------------------
  logic [31:0]        p;
  logic [30:0]        rm;
  logic [PW-1:0]      pos;
  logic [AW-1:0]      rd_addr;
  logic [17:0]        u;
  third_t             third;
  logic [SHAPE_W-1:0] f;
  s1_t                s1_r, s1_nxt;

  always_comb begin
    p  = 32'(in_phase) << (32 - PHASE_BITS);
    // quadrants 1 and 3 run the table backward
    rm = p[30] ? (Q30_ONE - {1'b0, p[29:0]}) : {1'b0, p[29:0]};
    pos     = PW'(rm) * PW'(SINE_QUARTER_DEPTH);
    rd_addr = pos[PW-1:30];

    u = {2'b00, in_shape} + {1'b0, in_shape, 1'b0};
    priority if (u == U_FULL) begin
      // knob at full scale: pure square
      third = THIRD_SAW_SQUARE;
      f     = F_FULL;
    end else if (u >= U_TWO_THIRDS) begin
      third = THIRD_SAW_SQUARE;
      f     = SHAPE_W'(u - U_TWO_THIRDS);
    end else if (u >= U_ONE_THIRD) begin
      third = THIRD_TRI_SAW;
      f     = SHAPE_W'(u - U_ONE_THIRD);
    end else begin
      third = THIRD_SINE_TRI;
      f     = u[SHAPE_W-1:0];
    end

    s1_nxt = '{quad: p[31:30], frac: pos[29:0], p: p, third: third, f: f};
  end

  // stage 1: decoded transaction, aligned with the ROM read data
  always_ff @(posedge clk) begin
    if (ctl.s1) begin
      s1_r <= s1_nxt;
    end
  end

  logic [TAB_W-1:0] rom_a, rom_b;

  mws_sine_rom #(
    .DEPTH (SINE_QUARTER_DEPTH),
    .AW    (AW)
  ) u_rom (
    .clk     (clk),
    .rd_en   (ctl.s1),
    .rd_addr (rd_addr),
    .rd_a    (rom_a),
    .rd_b    (rom_b)
  );

  // stages 2 and 3: sine interpolation and wave selection
  logic signed [WAVE_W-1:0] w_lo, w_hi;
  logic [SHAPE_W-1:0]       w_f;

  mws_wave u_wave (
    .clk   (clk),
    .ctl   (ctl),
    .s1    (s1_r),
    .rom_a (rom_a),
    .rom_b (rom_b),
    .lo    (w_lo),
    .hi    (w_hi),
    .f     (w_f)
  );

  // stages 4 to 6 and the output register: crossfade, divide, round, saturate
  mws_mix #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mix (
    .clk    (clk),
    .ctl    (ctl),
    .lo     (w_lo),
    .hi     (w_hi),
    .f      (w_f),
    .sample (out_sample)
  );

`ifndef SYNTHESIS
  // intake stalls only when every stage and the output register are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&vld_r) && out_valid_r))
    else $error("input stalled with an empty pipeline slot");

  // a taken result with nothing behind it leaves the output empty
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !vld_r[NST-1]) |=> !out_valid_r)
    else $error("result repeated after transaction");

  // reset empties the whole pipeline
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && (vld_r == '0)))
    else $error("pipeline not cleared by reset");
`endif

endmodule

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mws_pkg::*;

  // Fixed-point anchors of the morph math, held at 64 bits so that no product overflows.
  localparam longint Q30        = 64'sd1073741824;
  localparam longint Q31        = 64'sd2147483648;
  localparam longint Q32        = 64'sd4294967296;
  localparam longint KNOB_FULL  = 64'sd65535;
  localparam int     KNOB_THIRD = 21845;
  localparam int     SINE_DEPTH = 256;
  localparam int     SAMPLE_W   = 16;
  localparam int     ROUND_SH   = 32 - SAMPLE_W;
  localparam int     DIR_ROWS   = 23;
  localparam int     RAND_ITEMS = 1530;
  localparam int     DRAIN      = 24;   // pipeline is 7 deep; leave plenty of slack

  typedef struct packed {
    logic [15:0]        phase;
    logic [15:0]        shape;
    logic               known;
    logic signed [15:0] sample;
  } dir_row_t;

  typedef struct {
    bit                 known;
    logic signed [15:0] sample;
  } fixed_answer_t;

  typedef struct {
    logic [15:0]        phase;
    logic [15:0]        shape;
    logic signed [15:0] sample;
  } sample_expect_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [15:0]                in_phase;
  logic [SHAPE_W-1:0]         in_shape;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;

  // Quarter-wave sine in Q30, built once at time zero before the first edge.
  longint         sine_q30 [0:SINE_DEPTH];
  fixed_answer_t  fixed_answers[$];     // typed-in answer (or none) per driven transaction
  sample_expect_t pending_samples[$];   // samples owed by the block, oldest first
  sample_expect_t want;
  fixed_answer_t  ans;
  int             fault_count = 0;
  bit             calm = 1'b0;          // when set, both sides run without gaps

  morphing_waveform_sampler uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_phase   (in_phase),
    .in_shape   (in_shape),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sample predictor
  // ---------------------------------------------------------------------------

  // Build each entry from a truncated Taylor series up to x^17, then clamp to [0, 1.0].
  function automatic void build_sine_q30();
    longint x, x2, term, acc;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x    = (longint'(HALF_PI_Q30) * i) / SINE_DEPTH;
      x2   = (x * x) >>> 30;
      term = x;
      acc  = x;
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >>> 30) / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      if (acc < 0) acc = 0;
      if (acc > Q30) acc = Q30;
      sine_q30[i] = acc;
    end
  endfunction

  // Interpolate linearly between neighbor entries; r is a Q30 fraction of a quarter.
  function automatic longint quarter_sine(longint r);
    longint pos, idx, frac;
    pos  = r * SINE_DEPTH;
    idx  = pos >>> 30;
    frac = pos & (Q30 - 1);
    if (idx >= SINE_DEPTH) return sine_q30[SINE_DEPTH];
    return (sine_q30[idx] * (Q30 - frac) + sine_q30[idx + 1] * frac) >>> 30;
  endfunction

  // All waves are Q31 in [-2^31, 2^31] over a Q0.32 phase p.
  function automatic longint sine_wave(longint p);
    longint quad, r, mag;
    quad = (p >>> 30) & 3;
    r    = p & (Q30 - 1);
    mag  = (quad % 2 == 1) ? quarter_sine(Q30 - r) : quarter_sine(r);
    return (quad >= 2) ? -(2 * mag) : 2 * mag;
  endfunction

  function automatic longint tri_wave(longint p);
    if (p < Q30) return 2 * p;
    if (p <= 3 * Q30) return Q32 - 2 * p;   // middle piece includes phase 3/4
    return 2 * p - 2 * Q32;
  endfunction

  function automatic longint saw_wave(longint p);
    return (p < Q31) ? p : p - Q32;
  endfunction

  function automatic longint square_wave(longint p);
    return (p < Q31) ? Q31 : -Q31;
  endfunction

  function automatic logic signed [15:0] predict_sample(logic [15:0] phase,
                                                        logic [15:0] shape);
    longint p, u, f, lo, hi, sum, v, b, o, res;
    third_t third;
    p = longint'(phase) << 16;
    u = 3 * longint'(shape);
    // Full-scale knob lands past the last third; pin it to pure square.
    if (u >= 3 * KNOB_FULL) begin
      third = THIRD_SAW_SQUARE;
      f     = KNOB_FULL;
    end else begin
      third = third_t'(u / KNOB_FULL);
      f     = u % KNOB_FULL;
    end
    case (third)
      THIRD_SINE_TRI: begin
        lo = sine_wave(p);
        hi = tri_wave(p);
      end
      THIRD_TRI_SAW: begin
        lo = tri_wave(p);
        hi = saw_wave(p);
      end
      default: begin
        lo = saw_wave(p);
        hi = square_wave(p);
      end
    endcase
    // Crossfade on an offset value, round to nearest with halves down.
    sum = f * hi + (KNOB_FULL - f) * lo;
    v   = sum + KNOB_FULL * Q31;
    b   = (v + KNOB_FULL / 2) / KNOB_FULL;
    // Round half up into the output format, then saturate.
    o   = (b + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
    res = o - (64'sd1 <<< (SAMPLE_W - 1));
    if (res > (64'sd1 <<< (SAMPLE_W - 1)) - 1) res = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    if (res < -(64'sd1 <<< (SAMPLE_W - 1))) res = -(64'sd1 <<< (SAMPLE_W - 1));
    return res[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Favor quadrant edges, where the piecewise waves change direction.
  function automatic logic [15:0] pick_phase();
    if ($urandom_range(0, 3) == 0)
      return 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 4) - 2);
    return 16'($urandom);
  endfunction

  // Favor the knob ends and the third boundaries, where the crossfade switches waves.
  function automatic logic [15:0] pick_shape();
    if ($urandom_range(0, 3) == 0)
      return 16'(KNOB_THIRD * $urandom_range(0, 3) + $urandom_range(0, 4) - 2);
    return 16'($urandom);
  endfunction

  // Drop valid for a while; skip entirely for a zero gap so valid stays up.
  task automatic rest(int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Present one transaction and hold it until the block takes it.
  task automatic send_item(logic [15:0] phase, logic [15:0] shape,
                           bit known, logic signed [15:0] sample);
    fixed_answers.push_back('{known, sample});
    in_valid <= 1'b1;
    in_phase <= phase;
    in_shape <= shape;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic note_fault(string what, sample_expect_t e);
    fault_count++;
    if (fault_count <= 10)
      $display("%s: phase=%h shape=%h expected %0d got %0d",
               what, e.phase, e.shape, e.sample, out_sample);
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: record each accepted input, check each accepted output.
  // Both sides are sampled at the edge, before any update made at that edge lands.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      ans          = fixed_answers.pop_front();
      want.phase   = in_phase;
      want.shape   = in_shape;
      want.sample  = ans.known ? ans.sample : predict_sample(in_phase, in_shape);
      pending_samples.push_back(want);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        want = '{16'h0, 16'h0, 16'sh0};
        note_fault("unexpected sample", want);
      end else begin
        want = pending_samples.pop_front();
        if (out_sample !== want.sample) note_fault("sample mismatch", want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Downstream pacing: stall in bursts, none at all during calm stretches.
  // ---------------------------------------------------------------------------
  initial begin : out_pacer
    forever begin
      if (calm) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed table first, then random transactions.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t rows [DIR_ROWS];
    // Known answers: sine and triangle meet at zero phase; +1.0 saturates;
    // -1.0 lands on the most negative code.
    rows = '{
      '{16'h0000, 16'd0,     1'b1, 16'sd0},      // pure sine at zero
      '{16'h4000, 16'd0,     1'b0, 16'sd0},      // sine peak
      '{16'h8000, 16'd0,     1'b0, 16'sd0},
      '{16'hC000, 16'd0,     1'b0, 16'sd0},      // sine trough
      '{16'hFFFF, 16'd0,     1'b0, 16'sd0},
      '{16'h4000, 16'd21845, 1'b1, 16'sd32767},  // pure triangle, +1.0 saturates
      '{16'hC000, 16'd21845, 1'b1, -16'sd32768}, // triangle at 3/4 uses middle piece
      '{16'hC001, 16'd21845, 1'b0, 16'sd0},
      '{16'h0000, 16'd43690, 1'b1, 16'sd0},      // pure saw
      '{16'h7FFF, 16'd43690, 1'b1, 16'sd32767},
      '{16'h8000, 16'd43690, 1'b1, -16'sd32768}, // saw wraps at half period
      '{16'h0000, 16'd65535, 1'b1, 16'sd32767},  // full knob is pure square
      '{16'h7FFF, 16'd65535, 1'b1, 16'sd32767},
      '{16'h8000, 16'd65535, 1'b1, -16'sd32768},
      '{16'hFFFF, 16'd65535, 1'b1, -16'sd32768},
      '{16'h2000, 16'd10922, 1'b0, 16'sd0},      // mid sine/triangle blend
      '{16'h2000, 16'd21844, 1'b0, 16'sd0},      // either side of a third boundary
      '{16'h2000, 16'd21846, 1'b0, 16'sd0},
      '{16'h6000, 16'd43689, 1'b0, 16'sd0},
      '{16'h6000, 16'd43691, 1'b0, 16'sd0},
      '{16'hA000, 16'd65534, 1'b0, 16'sd0},      // just short of pure square
      '{16'h5555, 16'hAAAA,  1'b0, 16'sd0},      // alternating bit patterns
      '{16'hAAAA, 16'h5555,  1'b0, 16'sd0}
    };
    build_sine_q30();
    in_valid = 1'b0;
    in_phase = '0;
    in_shape = '0;
    rst_n    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      rest(pick_gap());
      send_item(rows[i].phase, rows[i].shape, rows[i].known, rows[i].sample);
    end

    // Pick a paced or calm stretch at random every hundred transactions.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      rest(calm ? 0 : pick_gap());
      send_item(pick_phase(), pick_shape(), 1'b0, 16'sd0);
    end
    in_valid <= 1'b0;

    // Let the last acceptance reach the scoreboard, drain, then watch for strays.
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fault_count == 0 && pending_samples.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #5000000;
    $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire
